/* sv/mslcg_pkg.sv */
package mslcg_pkg;

  localparam int unsigned StateW = 31;
  localparam int unsigned MultW  = 15;
  localparam int unsigned BoundW = 16;
  localparam int unsigned SpanW  = BoundW + 1;
  localparam int unsigned ProdW  = StateW + MultW;
  localparam int unsigned ScaleW = StateW + SpanW;

  // 2^31 - 1, the Mersenne prime modulus
  localparam logic [StateW-1:0] LcgModulus = 31'h7FFF_FFFF;
  localparam logic [MultW-1:0]  LcgMult    = 15'd16807;
  localparam logic [StateW-1:0] SeedReset  = 31'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FOLD,
    ST_SCALE,
    ST_DIV
  } ctrl_state_e;

  typedef struct packed {
    logic load_in;  // capture bounds, start state multiply
    logic fold;     // reduce product mod 2^31-1 into the state
    logic scale;    // multiply new state by span
    logic finish;   // form result into output register
  } ctrl_cmd_t;

endpackage

/* sv/mslcg_ctrl.sv */
module mslcg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mslcg_pkg::ctrl_cmd_t cmd_o
);
  import mslcg_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        // hold until the output register can take the result
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* sv/mslcg_dp.sv */
module mslcg_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mslcg_pkg::ctrl_cmd_t             cmd_i,
  input  logic                             cfg_we_i,
  input  logic [mslcg_pkg::StateW-1:0]     cfg_data_i,
  input  logic signed [mslcg_pkg::BoundW-1:0] bound_low_i,
  input  logic signed [mslcg_pkg::BoundW-1:0] bound_high_i,
  output logic signed [mslcg_pkg::BoundW-1:0] drawn_value_o,
  output logic                             bad_range_o
);
  import mslcg_pkg::*;

  logic [StateW-1:0] state_q, state_d;
  logic [ProdW-1:0]  mul_q;
  logic [ScaleW-1:0] scl_q;
  logic [SpanW-1:0]  span_q, span_d;
  logic [BoundW-1:0] lo_q;
  logic              bad_q, bad_d;
  logic [BoundW-1:0] drawn_q, drawn_d;
  logic              flag_q;

  logic [StateW:0]   fold_sum;
  logic [StateW-1:0] fold_res;
  logic [SpanW-1:0]  quo;
  logic [StateW:0]   quo_sum;
  logic [SpanW-1:0]  off;

  // p mod (2^31-1) = hi + lo, then at most one subtract
  assign fold_sum = {1'b0, mul_q[StateW-1:0]} + (StateW+1)'(mul_q[ProdW-1:StateW]);
  assign fold_res = (fold_sum >= {1'b0, LcgModulus}) ?
                    StateW'(fold_sum - {1'b0, LcgModulus}) : fold_sum[StateW-1:0];

  // x / (2^31-1) = q + ((q + l) >= M), with x = q*2^31 + l
  assign quo     = scl_q[ScaleW-1:StateW];
  assign quo_sum = (StateW+1)'(quo) + {1'b0, scl_q[StateW-1:0]};
  assign off     = quo + SpanW'(quo_sum >= {1'b0, LcgModulus});

  assign span_d  = {bound_high_i[BoundW-1], bound_high_i}
                 - {bound_low_i[BoundW-1], bound_low_i} + SpanW'(1);
  assign bad_d   = bound_high_i < bound_low_i;
  assign drawn_d = bad_q ? lo_q : lo_q + off[BoundW-1:0];

  always_comb begin
    state_d = state_q;
    if (cfg_we_i) begin
      state_d = cfg_data_i;
    end else if (cmd_i.fold) begin
      state_d = fold_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SeedReset;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mul_q  <= ProdW'(state_q) * ProdW'(LcgMult);
      span_q <= span_d;
      lo_q   <= bound_low_i;
      bad_q  <= bad_d;
    end
    if (cmd_i.scale) begin
      scl_q <= ScaleW'(state_q) * ScaleW'(span_q);
    end
    if (cmd_i.finish) begin
      drawn_q <= drawn_d;
      flag_q  <= bad_q;
    end
  end

  assign drawn_value_o = $signed(drawn_q);
  assign bad_range_o   = flag_q;

endmodule

/* sv/minimal_standard_lcg_range_core.sv */
// The multiply into mul_q, fold into the state, scale into scl_q and divide into
// the output register run in turn, the divide waiting while the output is stalled.
// A new request is taken only once the divide step has passed the last one on.
// Reset (rst_ni low, asynchronous): state reloads to seed 1, controller idles,
// output register empties. A seed write reloads the state at once.
module minimal_standard_lcg_range_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration: seed register
  input  logic                                cfg_we_i,
  input  logic [mslcg_pkg::StateW-1:0]        cfg_data_i,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [mslcg_pkg::BoundW-1:0] bound_low_i,
  input  logic signed [mslcg_pkg::BoundW-1:0] bound_high_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [mslcg_pkg::BoundW-1:0] drawn_value_o,
  output logic                                bad_range_o
);
  import mslcg_pkg::*;

  // Commands from the sequencer: load_in on the accepting edge captures the
  // bounds and the state times 16807; fold reduces that modulo 2^31-1 into the
  // state; scale multiplies the new state by the span; finish divides by
  // 2^31-1 with a shift and one correction and adds the low bound.
  ctrl_cmd_t cmd;

  mslcg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  mslcg_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .bound_low_i   (bound_low_i),
    .bound_high_i  (bound_high_i),
    .drawn_value_o (drawn_value_o),
    .bad_range_o   (bad_range_o)
  );

`ifndef SYNTHESIS
  // an accepted request keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while a draw is in flight");

  // finishing a draw always presents a result
  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_valid_o)
    else $error("finished draw not presented");

  // sequencer issues at most one command per cycle
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_in, cmd.fold, cmd.scale, cmd.finish}))
    else $error("overlapping datapath commands");
`endif

endmodule

/* verif/minimal_standard_lcg_range_core_tb.sv */
`timescale 1ns / 100ps

// Ranged draws from the 16807 multiplicative generator. The testbench mirrors
// the generator state, derives each unpinned draw exactly in integers, and checks each
// result in order against the queue of pending draws.
module minimal_standard_lcg_range_core_tb;
  import mslcg_pkg::*;

  localparam int WatchdogLimit = 2000;  // cycles with neither side moving
  localparam int DrainPause    = 8;     // margin after the last draw comes back
  localparam int RandomPhases  = 5;
  localparam int PhaseRequests = 100;

  localparam logic signed [BoundW-1:0] BoundMin = 16'sh8000;
  localparam logic signed [BoundW-1:0] BoundMax = 16'sh7FFF;
  localparam logic [StateW-1:0]        SeedTop  = 31'd2147483646;  // largest legal seed

  typedef struct packed {
    logic signed [BoundW-1:0] value;
    logic                     bad;
  } draw_t;

  // One directed request. A set reseed bit loads the seed before the request;
  // a set pinned bit means the expected draw is given in the row itself.
  typedef struct packed {
    logic                     reseed;
    logic [StateW-1:0]        seed;
    logic signed [BoundW-1:0] lo;
    logic signed [BoundW-1:0] hi;
    logic                     pinned;
    logic signed [BoundW-1:0] value;
    logic                     bad;
  } request_row_t;

  localparam int DirectedRows = 22;

  request_row_t directed_rows [DirectedRows] = '{
    // from reset: the first draw scales 16807, far too small to move off low
    '{1'b0, 31'd0,     BoundMin,      BoundMax,      1'b1, BoundMin,      1'b0},
    '{1'b0, 31'd0,     16'sd5,        16'sd2,        1'b1, 16'sd5,        1'b1},
    '{1'b0, 31'd0,     BoundMax,      BoundMin,      1'b1, BoundMax,      1'b1},
    '{1'b0, 31'd0,     16'sd100,      16'sd100,      1'b1, 16'sd100,      1'b0},
    '{1'b0, 31'd0,     BoundMin,      BoundMin,      1'b1, BoundMin,      1'b0},
    '{1'b0, 31'd0,     BoundMax,      BoundMax,      1'b1, BoundMax,      1'b0},
    '{1'b0, 31'd0,     16'sd0,        16'sd9,        1'b0, 16'sd0,        1'b0},
    '{1'b0, 31'd0,     BoundMin,      BoundMax,      1'b0, 16'sd0,        1'b0},
    '{1'b0, 31'd0,     -16'sd1,       16'sd0,        1'b0, 16'sd0,        1'b0},
    // zero seed: the state is stuck at zero, every draw returns low
    '{1'b1, 31'd0,     BoundMin,      BoundMax,      1'b1, BoundMin,      1'b0},
    '{1'b0, 31'd0,     16'sd1234,     16'sd5000,     1'b1, 16'sd1234,     1'b0},
    '{1'b0, 31'd0,     16'sd7,        -16'sd7,       1'b1, 16'sd7,        1'b1},
    // seed equal to the modulus: the first advance lands on zero and stays
    '{1'b1, LcgModulus, -16'sd20,     16'sd20,       1'b1, -16'sd20,      1'b0},
    '{1'b0, 31'd0,     BoundMin,      BoundMax,      1'b1, BoundMin,      1'b0},
    // largest legal seed: the first state is p - 16807, the top of full range
    '{1'b1, SeedTop,   BoundMin,      BoundMax,      1'b1, BoundMax,      1'b0},
    '{1'b0, 31'd0,     BoundMin,      BoundMax,      1'b0, 16'sd0,        1'b0},
    '{1'b0, 31'd0,     16'sd0,        16'sd1,        1'b0, 16'sd0,        1'b0},
    '{1'b0, 31'd0,     -16'sd32767,   16'sd32766,    1'b0, 16'sd0,        1'b0},
    // back to the reset seed through the register
    '{1'b1, SeedReset, BoundMin,      BoundMax,      1'b1, BoundMin,      1'b0},
    '{1'b0, 31'd0,     16'sd10,       16'sd20,       1'b0, 16'sd0,        1'b0},
    '{1'b0, 31'd0,     16'sh5555,     16'shAAAA,     1'b1, 16'sh5555,     1'b1},
    '{1'b0, 31'd0,     16'shAAAA,     16'sh5555,     1'b0, 16'sd0,        1'b0}
  };

  // DUT ports; the inputs are known from time zero
  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     cfg_we_i     = 1'b0;
  logic [StateW-1:0]        cfg_data_i   = '0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_stall_o;
  logic signed [BoundW-1:0] bound_low_i  = '0;
  logic signed [BoundW-1:0] bound_high_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i  = 1'b1;
  logic signed [BoundW-1:0] drawn_value_o;
  logic                     bad_range_o;

  // Sideband that travels with each request: the typed-in expectation, if any
  logic                     req_pinned    = 1'b0;
  logic signed [BoundW-1:0] req_pin_value = '0;
  logic                     req_pin_bad   = 1'b0;

  draw_t             pending_draws [$];
  logic [StateW-1:0] lcg_state     = SeedReset;  // mirror of the generator state
  bit                no_gaps       = 1'b0;       // shared by both sides in a burst
  int                mismatches    = 0;
  int                idle_cycles   = 0;
  int                requests_seen = 0;
  int                results_seen  = 0;
  int                inverted_seen = 0;
  int                seeds_loaded  = 0;

  minimal_standard_lcg_range_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .bound_low_i  (bound_low_i),
    .bound_high_i (bound_high_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .drawn_value_o(drawn_value_o),
    .bad_range_o  (bad_range_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // One step of state * 16807 mod (2^31 - 1), done in 64 bits.
  function automatic logic [StateW-1:0] lcg_advance(logic [StateW-1:0] st);
    longint unsigned prod;
    prod = longint'(st) * longint'(LcgMult);
    return StateW'(prod % longint'(LcgModulus));
  endfunction

  // Map an advanced state onto [lo, hi]: lo + floor(state * span / (2^31 - 1)).
  function automatic draw_t scale_draw(logic [StateW-1:0] st,
                                       logic signed [BoundW-1:0] lo,
                                       logic signed [BoundW-1:0] hi);
    draw_t  d;
    longint span;
    longint off;
    if (hi < lo) begin
      d.value = lo;
      d.bad   = 1'b1;
    end else begin
      span    = longint'(hi) - longint'(lo) + 1;
      off     = (longint'(st) * span) / longint'(LcgModulus);
      d.value = lo + BoundW'(off);
      d.bad   = 1'b0;
    end
    return d;
  endfunction

  function automatic int pick_wait();
    return no_gaps ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic report_mismatch(string what, logic signed [31:0] got,
                                 logic signed [31:0] want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Called right after a rising edge. Hold valid across back-to-back requests,
  // drop it only when a gap is drawn.
  task automatic push_request(logic signed [BoundW-1:0] lo, logic signed [BoundW-1:0] hi,
                              logic pinned, draw_t pin);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    bound_low_i   <= lo;
    bound_high_i  <= hi;
    req_pinned    <= pinned;
    req_pin_value <= pin.value;
    req_pin_bad   <= pin.bad;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and wait until every outstanding draw has come back.
  task automatic drain_draws();
    in_valid_i <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk_i);
    repeat (DrainPause) @(posedge clk_i);
  endtask

  // Seed writes only go in while the block is idle.
  task automatic load_seed(logic [StateW-1:0] seed);
    drain_draws();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= seed;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic random_bounds(output logic signed [BoundW-1:0] lo,
                               output logic signed [BoundW-1:0] hi);
    int kind;
    int base;
    kind = $urandom_range(0, 9);
    lo   = BoundW'($urandom);
    hi   = BoundW'($urandom);
    case (kind)
      4, 5, 6: begin
        // narrow, well-ordered windows anywhere in the range
        base = int'($urandom_range(0, 65535 - 15)) - 32768;
        lo   = BoundW'(base);
        hi   = BoundW'(base + int'($urandom_range(0, 15)));
      end
      7: hi = lo;
      8: begin
        lo = BoundMin;
        if ($urandom_range(0, 1)) hi = BoundMax;
      end
      9: hi = BoundMax;
      default: ;  // fully random, about half of these inverted
    endcase
  endtask

  // Predictor and scoreboard. Every signal read here was last driven before
  // this edge, so the values seen are the ones the DUT sampled.
  always @(posedge clk_i) begin : scoreboard
    draw_t want;
    if (!rst_ni) begin
      lcg_state   = SeedReset;
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (cfg_we_i) begin
        lcg_state = cfg_data_i;
        seeds_loaded++;
      end
      // check before pushing: a result can never leave in its own request's cycle
      if (out_valid_o && !out_stall_i) begin
        idle_cycles = 0;
        results_seen++;
        if (pending_draws.size() == 0) begin
          report_mismatch("unexpected result, value", 32'(drawn_value_o), 0);
        end else begin
          want = pending_draws.pop_front();
          if (drawn_value_o !== want.value)
            report_mismatch("drawn_value", 32'(drawn_value_o), 32'(want.value));
          if (bad_range_o !== want.bad)
            report_mismatch("bad_range", {31'd0, bad_range_o}, {31'd0, want.bad});
        end
      end
      if (in_valid_i && !in_stall_o) begin
        idle_cycles = 0;
        requests_seen++;
        // advance even for pinned rows, the generator moves on every request
        lcg_state = lcg_advance(lcg_state);
        if (req_pinned) begin
          want.value = req_pin_value;
          want.bad   = req_pin_bad;
        end else begin
          want = scale_draw(lcg_state, bound_low_i, bound_high_i);
        end
        if (want.bad) inverted_seen++;
        pending_draws.push_back(want);
      end
    end
  end

  // Result side: stall for a drawn number of cycles, then take one result.
  initial begin : result_sink
    int hold;
    forever begin
      hold = pick_wait();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  initial begin : watchdog
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("%0t ns: no handshake for %0d cycles", $time, WatchdogLimit);
    $display("minimal_standard_lcg_range_core_tb failed");
    $finish;
  end

  initial begin : stimulus
    request_row_t             row;
    draw_t                    pin;
    logic signed [BoundW-1:0] lo;
    logic signed [BoundW-1:0] hi;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: bound extremes, inverted bounds, degenerate seeds.
    for (int i = 0; i < DirectedRows; i++) begin
      row = directed_rows[i];
      if (row.reseed) load_seed(row.seed);
      pin.value = row.value;
      pin.bad   = row.bad;
      push_request(row.lo, row.hi, row.pinned, pin);
    end

    // Random phases, each from a fresh seed; bursts with no gaps on either side.
    pin = '0;
    for (int p = 0; p < RandomPhases; p++) begin
      case ($urandom_range(0, 3))
        0:       load_seed(SeedTop);
        1:       load_seed(StateW'($urandom_range(1, 1000)));
        default: load_seed(StateW'($urandom_range(1, 2147483646)));
      endcase
      for (int n = 0; n < PhaseRequests; n++) begin
        if (n % 25 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        random_bounds(lo, hi);
        push_request(lo, hi, 1'b0, pin);
      end
    end
    no_gaps = 1'b0;

    drain_draws();
    if (pending_draws.size() != 0)
      report_mismatch("draws never returned", pending_draws.size(), 0);

    $display("Drew %0d values (%0d with inverted bounds), checked %0d results,",
             requests_seen, inverted_seen, results_seen);
    $display("across %0d seed loads including zero, the modulus and the top seed.",
             seeds_loaded);
    if (mismatches == 0) begin
      $display("minimal_standard_lcg_range_core_tb passed");
    end else begin
      $display("minimal_standard_lcg_range_core_tb failed");
    end
    $finish;
  end

endmodule

/* minimal_standard_lcg_range_core.f */
sv/mslcg_pkg.sv
sv/mslcg_ctrl.sv
sv/mslcg_dp.sv
sv/minimal_standard_lcg_range_core.sv
verif/minimal_standard_lcg_range_core_tb.sv
